@@ rtl/core/round_robin_task_queue_defines.svh @@
// assertion macros for the round-robin task queue
// expects clk and arst_n in the scope of use
`ifndef ROUND_ROBIN_TASK_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_TASK_QUEUE_DEFINES_SVH

// same-cycle implication
`define RRTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RRTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rrtq_pkg.sv @@
// shared types and constants of the round-robin task queue
// no dependencies
package rrtq_pkg;

	localparam int MAX_TASKS = 64;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	localparam int OP_W     = 3;
	localparam int TASK_W   = 6;
	localparam int NS_W     = 32;
	localparam int STATUS_W = 2;
	localparam int QCNT_W   = 7;

	localparam logic [NS_W-1:0] SLICE_RESET_NS = 32'd10000000;

	localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
	localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
	localparam logic [OP_W-1:0] OP_PICK  = 3'd2;
	localparam logic [OP_W-1:0] OP_DEQT  = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd4;
	localparam logic [OP_W-1:0] OP_TIMER = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd3;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} link_req_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [NS_W-1:0]  wdata;
		logic [IDX_W-1:0] raddr;
	} elap_req_t;

	typedef struct packed {
		logic [TASK_W-1:0]   result_task;
		logic                is_idle;
		logic                need_resched;
		logic                arm_timer;
		logic [NS_W-1:0]     timer_ns;
		logic [STATUS_W-1:0] status;
		logic [QCNT_W-1:0]   queue_count;
	} res_t;

endpackage

@@ rtl/core/rrtq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module rrtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/rrtq_ctrl.sv @@
// request sequencer: reads links and elapsed time, updates, writes back
// depends on rrtq_pkg
module rrtq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rrtq_pkg::OP_W-1:0]   operation,
	input  logic [rrtq_pkg::TASK_W-1:0] task_id,
	input  logic [rrtq_pkg::NS_W-1:0]   tick_ns,
	input  logic [rrtq_pkg::NS_W-1:0]   time_slice,
	output logic                     busy,
	output rrtq_pkg::link_req_t      next_req,
	input  logic [rrtq_pkg::IDX_W-1:0]  next_rdata,
	output rrtq_pkg::link_req_t      prev_req,
	input  logic [rrtq_pkg::IDX_W-1:0]  prev_rdata,
	output rrtq_pkg::elap_req_t      elap_req,
	input  logic [rrtq_pkg::NS_W-1:0]   elap_rdata,
	output rrtq_pkg::res_t           res,
	output logic                     done
);
	import rrtq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RD, S_EX} state_t;

	state_t               state_q;
	logic [OP_W-1:0]      op_q;
	logic [IDX_W-1:0]     tid_q;
	logic                 tok_q;
	logic [NS_W-1:0]      ns_q;
	logic [MAX_TASKS-1:0] queued_q;
	logic [MAX_TASKS-1:0] elap_vld_q;
	logic [IDX_W-1:0]     head_q;
	logic [IDX_W-1:0]     tail_q;
	logic [CNT_W-1:0]     cnt_q;
	res_t                 res_q;
	logic                 done_q;

	logic             ex;
	logic [IDX_W-1:0] link_tgt;
	logic [NS_W-1:0]  elap_cur;
	logic [NS_W:0]    sum;
	logic [NS_W-1:0]  sum_sat;
	logic             do_push;
	logic             do_unlink;
	logic             ev_set;
	logic             ev_clr;
	logic [IDX_W-1:0] ev_idx;
	logic             elap_we;
	logic             next_we;
	logic             prev_we;
	logic [IDX_W-1:0] next_waddr;
	logic [IDX_W-1:0] next_wdata;
	logic [IDX_W-1:0] prev_waddr;
	logic [IDX_W-1:0] prev_wdata;
	logic [IDX_W-1:0] head_n;
	logic [IDX_W-1:0] tail_n;
	logic [CNT_W-1:0] cnt_n;
	res_t             res_n;

	assign ex = (state_q == S_EX);

	always_comb begin
		case (op_q)
			OP_DEQ:  link_tgt = tid_q;
			OP_PICK: link_tgt = head_q;
			default: link_tgt = tail_q;
		endcase
	end

	assign elap_cur = elap_vld_q[tid_q] ? elap_rdata : '0;
	assign sum      = {1'b0, elap_cur} + {1'b0, ns_q};
	assign sum_sat  = sum[NS_W] ? '1 : sum[NS_W-1:0];

	always_comb begin
		do_push   = 1'b0;
		do_unlink = 1'b0;
		ev_set    = 1'b0;
		ev_clr    = 1'b0;
		ev_idx    = tid_q;
		elap_we   = 1'b0;
		res_n     = '0;
		res_n.status = ST_OK;
		case (op_q)
			OP_ENQ: begin
				if (!tok_q) begin
					res_n.status = ST_NOT_QUEUED;
				end else if (queued_q[tid_q]) begin
					res_n.status = ST_ALREADY;
				end else begin
					do_push = 1'b1;
					ev_clr  = 1'b1;
				end
			end
			OP_DEQ: begin
				if (!tok_q || !queued_q[tid_q]) begin
					res_n.status = ST_NOT_QUEUED;
				end else begin
					do_unlink = 1'b1;
				end
			end
			OP_PICK: begin
				if (cnt_q == '0) begin
					res_n.is_idle = 1'b1;
					res_n.status  = ST_EMPTY;
				end else begin
					do_unlink = 1'b1;
					ev_clr    = 1'b1;
					ev_idx    = head_q;
					res_n.result_task = TASK_W'(head_q);
				end
			end
			OP_DEQT: begin
				if (cnt_q == '0) begin
					res_n.status = ST_EMPTY;
				end else begin
					do_unlink = 1'b1;
					res_n.result_task = TASK_W'(tail_q);
				end
			end
			OP_TICK: begin
				if (!tok_q) begin
					res_n.status = ST_NOT_QUEUED;
				end else if (sum_sat >= time_slice) begin
					ev_clr = 1'b1;
					res_n.need_resched = 1'b1;
				end else begin
					elap_we = 1'b1;
					ev_set  = 1'b1;
				end
			end
			OP_TIMER: begin
				if (!tok_q) begin
					res_n.status = ST_NOT_QUEUED;
				end else if (elap_cur == '0) begin
					res_n.arm_timer = 1'b1;
					res_n.timer_ns  = time_slice;
				end
			end
			default: begin
			end
		endcase

		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_waddr = prev_rdata;
		next_wdata = next_rdata;
		prev_waddr = next_rdata;
		prev_wdata = prev_rdata;
		head_n     = head_q;
		tail_n     = tail_q;
		cnt_n      = cnt_q;
		if (do_push) begin
			next_we    = (cnt_q != '0);
			prev_we    = (cnt_q != '0);
			next_waddr = tail_q;
			next_wdata = tid_q;
			prev_waddr = tid_q;
			prev_wdata = tail_q;
			if (cnt_q == '0) begin
				head_n = tid_q;
			end
			tail_n = tid_q;
			cnt_n  = cnt_q + CNT_W'(1);
		end else if (do_unlink) begin
			next_we = (link_tgt != head_q);
			prev_we = (link_tgt != tail_q);
			if (link_tgt == head_q) begin
				head_n = next_rdata;
			end
			if (link_tgt == tail_q) begin
				tail_n = prev_rdata;
			end
			cnt_n = cnt_q - CNT_W'(1);
			if (cnt_n == '0) begin
				head_n = '0;
				tail_n = '0;
			end
		end
		res_n.queue_count = QCNT_W'(cnt_n);
	end

	assign next_req = '{we: ex && next_we, waddr: next_waddr, wdata: next_wdata,
		raddr: link_tgt};
	assign prev_req = '{we: ex && prev_we, waddr: prev_waddr, wdata: prev_wdata,
		raddr: link_tgt};
	assign elap_req = '{we: ex && elap_we, waddr: tid_q, wdata: sum_sat, raddr: tid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			queued_q   <= '0;
			elap_vld_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						tid_q   <= IDX_W'(task_id);
						tok_q   <= (32'(task_id) < 32'(MAX_TASKS));
						ns_q    <= tick_ns;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (do_push) begin
						queued_q[tid_q] <= 1'b1;
					end else if (do_unlink) begin
						queued_q[link_tgt] <= 1'b0;
					end
					if (ev_clr) begin
						elap_vld_q[ev_idx] <= 1'b0;
					end else if (ev_set) begin
						elap_vld_q[ev_idx] <= 1'b1;
					end
					head_q  <= head_n;
					tail_q  <= tail_n;
					cnt_q   <= cnt_n;
					res_q   <= res_n;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res  = res_q;
	assign done = done_q;

endmodule

@@ rtl/core/round_robin_task_queue.sv @@
// round-robin run queue top level: slice register, link and elapsed-time rams
// depends on rrtq_pkg, rrtq_ram, rrtq_ctrl and round_robin_task_queue_defines.svh

// A request is taken at a clock edge with start high and busy low; busy then
// stays high while the link and elapsed-time rams are read and written back,
// and the result is shown with done high for exactly one cycle, the cycle in
// which busy is low again. A new request may be started in that same cycle.
// A request passes the registered read of the rams, then an update-and-write
// step. The result is held only until the next request completes: whoever
// consumes it must capture it while done is high. The slice register may
// only be written while busy is low and no result is pending.
`include "round_robin_task_queue_defines.svh"

module round_robin_task_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rrtq_pkg::OP_W-1:0]           operation,
	input  logic [rrtq_pkg::TASK_W-1:0]         task_id,
	input  logic [rrtq_pkg::NS_W-1:0]           tick_ns,
	input  logic                                cfg_we,
	input  logic [rrtq_pkg::NS_W-1:0]           cfg_wdata,
	output logic                                done,
	output logic [rrtq_pkg::TASK_W-1:0]         result_task,
	output logic                                is_idle,
	output logic                                need_resched,
	output logic                                arm_timer,
	output logic [rrtq_pkg::NS_W-1:0]           timer_ns,
	output logic [rrtq_pkg::STATUS_W-1:0]       status,
	output logic [rrtq_pkg::QCNT_W-1:0]         queue_count
);
	import rrtq_pkg::*;

	logic [NS_W-1:0]  slice_q;
	link_req_t        next_req;
	link_req_t        prev_req;
	elap_req_t        elap_req;
	logic [IDX_W-1:0] next_rdata;
	logic [IDX_W-1:0] prev_rdata;
	logic [NS_W-1:0]  elap_rdata;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET_NS;
		end else if (cfg_we) begin
			slice_q <= cfg_wdata;
		end
	end

	rrtq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_next_ram (
		.clk   (clk),
		.we    (next_req.we),
		.waddr (next_req.waddr),
		.wdata (next_req.wdata),
		.raddr (next_req.raddr),
		.rdata (next_rdata)
	);

	rrtq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_prev_ram (
		.clk   (clk),
		.we    (prev_req.we),
		.waddr (prev_req.waddr),
		.wdata (prev_req.wdata),
		.raddr (prev_req.raddr),
		.rdata (prev_rdata)
	);

	rrtq_ram #(.WIDTH(NS_W), .DEPTH(MAX_TASKS)) u_elap_ram (
		.clk   (clk),
		.we    (elap_req.we),
		.waddr (elap_req.waddr),
		.wdata (elap_req.wdata),
		.raddr (elap_req.raddr),
		.rdata (elap_rdata)
	);

	rrtq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.task_id    (task_id),
		.tick_ns    (tick_ns),
		.time_slice (slice_q),
		.busy       (busy),
		.next_req   (next_req),
		.next_rdata (next_rdata),
		.prev_req   (prev_req),
		.prev_rdata (prev_rdata),
		.elap_req   (elap_req),
		.elap_rdata (elap_rdata),
		.res        (res),
		.done       (done)
	);

	assign result_task  = res.result_task;
	assign is_idle      = res.is_idle;
	assign need_resched = res.need_resched;
	assign arm_timer    = res.arm_timer;
	assign timer_ns     = res.timer_ns;
	assign status       = res.status;
	assign queue_count  = res.queue_count;

	`RRTQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`RRTQ_ASSERT_IMP(a_done_free, done, !busy, "result shown while still busy")
	`RRTQ_ASSERT_IMP(a_idle_empty, done && is_idle, (status == ST_EMPTY) && (queue_count == '0), "idle result with nonempty queue")
	`RRTQ_ASSERT_IMP(a_err_no_task, done && (status != ST_OK), (result_task == '0) && !arm_timer && !need_resched, "error result carries a task")

endmodule
